// ===== rtl/line_fit_steering_error_assert.svh =====
// assertion macros for the line fit block
`ifndef LINE_FIT_STEERING_ERROR_ASSERT_SVH
`define LINE_FIT_STEERING_ERROR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define LFSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LFSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lfse_pkg.sv =====
package lfse_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int ROW_ADDR_W = $clog2(MAX_ROWS);
  localparam int CNT_W      = $clog2(MAX_ROWS + 1);
  localparam int FRAC_BITS  = 8;
  localparam int COL_W      = 8;

  localparam int DIV_NUM_W  = 40;
  localparam int DIV_DEN_W  = 24;

  localparam int ERR_DIVISOR = 100;
  // ceil(2^37 / 100), exact for error magnitudes below 2^30
  localparam logic [30:0] ERR_RECIP       = 31'd1374389535;
  localparam int          ERR_RECIP_SHIFT = 37;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_MIDDLE   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_THRESHOLD = 1'b1;

  localparam logic [7:0] IMAGE_MIDDLE_RESET   = 8'd128;
  localparam logic [7:0] TURN_THRESHOLD_RESET = 8'd15;

  localparam logic [1:0] DIR_FORWARD = 2'd0;
  localparam logic [1:0] DIR_LEFT    = 2'd1;
  localparam logic [1:0] DIR_RIGHT   = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_PASS,
    ST_FIT0, ST_FIT1, ST_FIT2, ST_FIT3, ST_FIT4, ST_FIT5, ST_FIT6,
    ST_FIT7, ST_FIT8, ST_FIT9, ST_FIT10, ST_FIT11, ST_FIT12,
    ST_SL_START, ST_SL_WAIT,
    ST_OF_START, ST_OF_WAIT,
    ST_VA_START, ST_VA_WAIT, ST_VA_TAKE,
    ST_ER_PREP, ST_ER_START, ST_ER_WAIT, ST_ER_TAKE,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_PASS,
    OP_FIT0, OP_FIT1, OP_FIT2, OP_FIT3, OP_FIT4, OP_FIT5, OP_FIT6,
    OP_FIT7, OP_FIT8, OP_FIT9, OP_FIT10, OP_FIT11, OP_FIT12,
    OP_SLOPE_START,
    OP_OFFSET_START,
    OP_VAR_START,
    OP_VAR_TAKE,
    OP_ERR_PREP,
    OP_ERR_START,
    OP_ERR_TAKE,
    OP_WAIT,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } cmd_t;

  typedef struct packed {
    logic pass_done;
    logic n_zero;
    logic div_busy;
  } status_t;

endpackage

// ===== rtl/lfse_ram.sv =====
module lfse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lfse_div.sv =====
module lfse_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [lfse_pkg::DIV_NUM_W-1:0]  num,
  input  logic [lfse_pkg::DIV_DEN_W-1:0]  den,
  output logic                            busy,
  output logic [lfse_pkg::DIV_NUM_W-1:0]  quot
);

  localparam int NW = lfse_pkg::DIV_NUM_W;
  localparam int DW = lfse_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;

  // one quotient bit a cycle, restoring
  assign trial = {rem, quot[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
      dreg <= den;
    end else if (busy) begin
      if (trial >= {1'b0, dreg}) begin
        rem  <= DW'(trial - {1'b0, dreg});
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem  <= trial[DW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/lfse_datapath.sv =====
module lfse_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  lfse_pkg::cmd_t                    cmd,
  output lfse_pkg::status_t                 status,
  input  logic [5:0]                        row_index,
  input  logic [7:0]                        centre_column,
  input  logic                              cfg_write,
  input  logic [lfse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lfse_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic signed [23:0]                steer_error,
  output logic [1:0]                        turn_direction,
  output logic signed [15:0]                line_slope,
  output logic signed [16:0]                centre_offset,
  output logic [15:0]                       column_variance,
  output logic [6:0]                        valid_points
);

  localparam int AW = lfse_pkg::ROW_ADDR_W;
  localparam int CW = lfse_pkg::CNT_W;
  localparam int NW = lfse_pkg::DIV_NUM_W;
  localparam int DW = lfse_pkg::DIV_DEN_W;
  localparam int FB = lfse_pkg::FRAC_BITS;

  function automatic logic signed [NW:0] sat_mag(input logic neg, input logic [NW-1:0] mag,
                                                 input int bits);
    logic [NW:0] lim;
    logic [NW:0] magx;
    lim  = (NW+1)'(1) << (bits - 1);
    magx = {1'b0, mag};
    if (!neg) begin
      sat_mag = (magx > lim - 1'b1) ? $signed(lim - 1'b1) : $signed(magx);
    end else begin
      sat_mag = (magx > lim) ? -$signed(lim) : -$signed(magx);
    end
  endfunction

  // configuration
  logic [7:0] image_middle;
  logic [7:0] turn_threshold;

  // frame sums
  logic [CW-1:0]   point_count;
  logic [11:0]     row_sum;
  logic [13:0]     column_sum;
  logic [19:0]     row_column_sum;
  logic [17:0]     row_square_sum;
  logic [lfse_pkg::MAX_ROWS-1:0] row_written;

  // variance pass
  logic [AW:0]     pass_idx;
  logic            pipe_ok;
  logic [CW-1:0]   m_acc;
  logic [13:0]     p_acc;
  logic [22:0]     q_acc;
  logic [7:0]      rdata;

  // shared multiplier and fit terms
  logic [27:0]        mul_a;
  logic [13:0]        mul_b;
  logic [35:0]        prod;
  logic signed [28:0] up;
  logic signed [24:0] down;
  logic signed [15:0] off_num;
  logic [12:0]        nsq;
  logic [27:0]        sxsq;
  logic [27:0]        psx;
  logic signed [39:0] numer;
  logic [18:0]        ncube;
  logic signed [33:0] esum;

  // results
  logic signed [23:0] prev_error;
  logic signed [15:0] held_slope;
  logic [15:0]        held_variance;
  logic signed [16:0] offset_res;
  logic [1:0]         dir;

  // divider
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_busy;
  logic [NW-1:0] div_quot;
  logic          div_neg;
  logic          div_neg_next;

  logic [28:0] up_mag;
  logic [15:0] off_mag;
  logic [33:0] esum_mag;
  logic [29:0] err_rnd;
  logic [60:0] err_prod;
  logic signed [NW:0] sat_sl;
  logic signed [NW:0] sat_of;
  logic signed [NW:0] sat_er;
  logic signed [24:0] err_x;
  logic signed [24:0] thr_q;
  logic signed [23:0] err_new;
  logic               down_zero;

  lfse_ram #(
    .WIDTH (lfse_pkg::COL_W),
    .DEPTH (lfse_pkg::MAX_ROWS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (AW'(row_index)),
    .wdata (centre_column),
    .raddr (pass_idx[AW-1:0]),
    .rdata (rdata)
  );

  lfse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign up_mag    = up[28] ? 29'(-up) : 29'(up);
  assign off_mag   = off_num[15] ? 16'(-off_num) : 16'(off_num);
  assign esum_mag  = esum[33] ? 34'(-esum) : 34'(esum);
  assign down_zero = (down == '0);

  assign status.pass_done = (pass_idx == (AW+1)'(lfse_pkg::MAX_ROWS));
  assign status.n_zero    = (point_count == '0);
  assign status.div_busy  = div_busy;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      lfse_pkg::OP_FIT0:  begin mul_a = 28'(row_column_sum); mul_b = 14'(point_count); end
      lfse_pkg::OP_FIT1:  begin mul_a = 28'(row_sum);        mul_b = column_sum;       end
      lfse_pkg::OP_FIT2:  begin mul_a = 28'(row_square_sum); mul_b = 14'(point_count); end
      lfse_pkg::OP_FIT3:  begin mul_a = 28'(row_sum);        mul_b = 14'(row_sum);     end
      lfse_pkg::OP_FIT4:  begin mul_a = 28'(image_middle);   mul_b = 14'(point_count); end
      lfse_pkg::OP_FIT5:  begin mul_a = 28'(point_count);    mul_b = 14'(point_count); end
      lfse_pkg::OP_FIT6:  begin mul_a = 28'(column_sum);     mul_b = column_sum;       end
      lfse_pkg::OP_FIT7:  begin mul_a = 28'(q_acc);          mul_b = 14'(nsq);         end
      lfse_pkg::OP_FIT8:  begin mul_a = 28'(p_acc);          mul_b = column_sum;       end
      lfse_pkg::OP_FIT9:  begin mul_a = sxsq;                mul_b = 14'(m_acc);       end
      lfse_pkg::OP_FIT10: begin mul_a = psx;                 mul_b = 14'(point_count); end
      lfse_pkg::OP_FIT11: begin mul_a = 28'(nsq);            mul_b = 14'(point_count); end
      default: ;
    endcase
  end

  // divider operand select, rounding half added to the magnitude for slope and offset
  always_comb begin
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    div_neg_next = div_neg;
    case (cmd.op)
      lfse_pkg::OP_SLOPE_START: begin
        div_start    = !down_zero;
        div_num      = (NW'(up_mag) << FB) + NW'(down[23:1]);
        div_den      = down[23:0];
        div_neg_next = up[28];
      end
      lfse_pkg::OP_OFFSET_START: begin
        div_start    = 1'b1;
        div_num      = (NW'(off_mag) << FB) + NW'(point_count[CW-1:1]);
        div_den      = DW'(point_count);
        div_neg_next = off_num[15];
      end
      lfse_pkg::OP_VAR_START: begin
        div_start    = 1'b1;
        div_num      = numer[39] ? '0 : NW'(numer);
        div_den      = DW'(ncube);
        div_neg_next = 1'b0;
      end
      default: ;
    endcase
  end

  // error magnitude stays below 2^30, so the reciprocal product is exact
  assign err_rnd = 30'(esum_mag) + 30'(lfse_pkg::ERR_DIVISOR / 2);

  assign sat_sl  = sat_mag(div_neg, div_quot, 16);
  assign sat_of  = sat_mag(div_neg, div_quot, 17);
  assign sat_er  = sat_mag(esum[33], NW'(err_prod[lfse_pkg::ERR_RECIP_SHIFT +: 24]), 24);
  assign err_new = sat_er[23:0];
  assign err_x   = 25'(err_new);
  assign thr_q   = 25'($signed({1'b0, 16'(turn_threshold) << FB}));

  always_comb begin
    if (err_x < -thr_q) begin
      dir = lfse_pkg::DIR_LEFT;
    end else if (err_x > thr_q) begin
      dir = lfse_pkg::DIR_RIGHT;
    end else begin
      dir = lfse_pkg::DIR_FORWARD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_middle   <= lfse_pkg::IMAGE_MIDDLE_RESET;
      turn_threshold <= lfse_pkg::TURN_THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lfse_pkg::REG_IMAGE_MIDDLE:   image_middle   <= cfg_data;
        lfse_pkg::REG_TURN_THRESHOLD: turn_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // sums, written flags and pass control
  always_ff @(posedge clk) begin
    if (rst || cmd.op == lfse_pkg::OP_CLEAR) begin
      point_count    <= '0;
      row_sum        <= '0;
      column_sum     <= '0;
      row_column_sum <= '0;
      row_square_sum <= '0;
      row_written    <= '0;
    end else if (cmd.accept) begin
      row_written[AW'(row_index)] <= 1'b1;
      if (centre_column != '0 && point_count != CW'(lfse_pkg::MAX_ROWS)) begin
        point_count    <= point_count + 1'b1;
        row_sum        <= row_sum + 12'(row_index);
        column_sum     <= column_sum + 14'(centre_column);
        row_column_sum <= row_column_sum + 20'(row_index * centre_column);
        row_square_sum <= row_square_sum + 18'(row_index * row_index);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op != lfse_pkg::OP_PASS) begin
      pass_idx <= '0;
      pipe_ok  <= 1'b0;
    end else begin
      // read data lands in the cycle after the address
      pipe_ok <= !status.pass_done && row_written[pass_idx[AW-1:0]];
      if (!status.pass_done) begin
        pass_idx <= pass_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == lfse_pkg::OP_IDLE) begin
      m_acc <= '0;
      p_acc <= '0;
      q_acc <= '0;
    end else if (cmd.op == lfse_pkg::OP_PASS && pipe_ok && rdata != '0) begin
      m_acc <= m_acc + 1'b1;
      p_acc <= p_acc + 14'(rdata);
      q_acc <= q_acc + 23'(rdata * rdata);
    end
  end

  always_ff @(posedge clk) begin
    prod    <= 36'(mul_a * mul_b);
    div_neg <= div_neg_next;
    case (cmd.op)
      lfse_pkg::OP_PASS:  offset_res <= '0;
      lfse_pkg::OP_FIT1:  up      <= $signed(29'(prod));
      lfse_pkg::OP_FIT2:  up      <= up - $signed(29'(prod));
      lfse_pkg::OP_FIT3:  down    <= $signed(25'(prod));
      lfse_pkg::OP_FIT4:  down    <= down - $signed(25'(prod));
      lfse_pkg::OP_FIT5:  off_num <= $signed({2'b00, column_sum}) - $signed(16'(prod));
      lfse_pkg::OP_FIT6:  nsq     <= 13'(prod);
      lfse_pkg::OP_FIT7:  sxsq    <= 28'(prod);
      lfse_pkg::OP_FIT8:  numer   <= $signed(40'(prod));
      lfse_pkg::OP_FIT9:  psx     <= 28'(prod);
      lfse_pkg::OP_FIT10: numer   <= numer + $signed(40'(prod));
      lfse_pkg::OP_FIT11: numer   <= numer - $signed(40'({prod, 1'b0}));
      lfse_pkg::OP_FIT12: ncube   <= 19'(prod);
      lfse_pkg::OP_VAR_START: offset_res <= sat_of[16:0];
      lfse_pkg::OP_ERR_PREP: begin
        // 0.32, 0.08 and 0.8 scaled by 100
        esum <= (34'(offset_res) <<< 5) + (34'(held_slope) <<< 3)
              + (34'(prev_error) <<< 6) + (34'(prev_error) <<< 4);
      end
      lfse_pkg::OP_ERR_START: err_prod <= 61'(err_rnd * lfse_pkg::ERR_RECIP);
      lfse_pkg::OP_ERR_TAKE: turn_direction <= dir;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error    <= '0;
      held_slope    <= '0;
      held_variance <= '0;
    end else begin
      case (cmd.op)
        lfse_pkg::OP_OFFSET_START: begin
          held_slope <= down_zero ? 16'sd0 : sat_sl[15:0];
        end
        lfse_pkg::OP_VAR_TAKE: begin
          held_variance <= (div_quot > NW'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
        end
        lfse_pkg::OP_ERR_TAKE: prev_error <= err_new;
        default: ;
      endcase
    end
  end

  assign steer_error     = prev_error;
  assign line_slope      = held_slope;
  assign centre_offset   = offset_res;
  assign column_variance = held_variance;
  assign valid_points    = 7'(point_count);

endmodule

// ===== rtl/lfse_ctrl.sv =====
module lfse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_row,
  input  logic              out_stall,
  input  lfse_pkg::status_t status,
  output lfse_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              out_valid
);

  lfse_pkg::ctl_state_t state;
  lfse_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = lfse_pkg::OP_WAIT;
    cmd.accept = 1'b0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      lfse_pkg::ST_IDLE: begin
        cmd.op     = lfse_pkg::OP_IDLE;
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && last_row) begin
          state_next = lfse_pkg::ST_PASS;
        end
      end
      lfse_pkg::ST_PASS: begin
        cmd.op = lfse_pkg::OP_PASS;
        if (status.pass_done) begin
          state_next = status.n_zero ? lfse_pkg::ST_ER_PREP : lfse_pkg::ST_FIT0;
        end
      end
      lfse_pkg::ST_FIT0:  begin cmd.op = lfse_pkg::OP_FIT0;  state_next = lfse_pkg::ST_FIT1;  end
      lfse_pkg::ST_FIT1:  begin cmd.op = lfse_pkg::OP_FIT1;  state_next = lfse_pkg::ST_FIT2;  end
      lfse_pkg::ST_FIT2:  begin cmd.op = lfse_pkg::OP_FIT2;  state_next = lfse_pkg::ST_FIT3;  end
      lfse_pkg::ST_FIT3:  begin cmd.op = lfse_pkg::OP_FIT3;  state_next = lfse_pkg::ST_FIT4;  end
      lfse_pkg::ST_FIT4:  begin cmd.op = lfse_pkg::OP_FIT4;  state_next = lfse_pkg::ST_FIT5;  end
      lfse_pkg::ST_FIT5:  begin cmd.op = lfse_pkg::OP_FIT5;  state_next = lfse_pkg::ST_FIT6;  end
      lfse_pkg::ST_FIT6:  begin cmd.op = lfse_pkg::OP_FIT6;  state_next = lfse_pkg::ST_FIT7;  end
      lfse_pkg::ST_FIT7:  begin cmd.op = lfse_pkg::OP_FIT7;  state_next = lfse_pkg::ST_FIT8;  end
      lfse_pkg::ST_FIT8:  begin cmd.op = lfse_pkg::OP_FIT8;  state_next = lfse_pkg::ST_FIT9;  end
      lfse_pkg::ST_FIT9:  begin cmd.op = lfse_pkg::OP_FIT9;  state_next = lfse_pkg::ST_FIT10; end
      lfse_pkg::ST_FIT10: begin cmd.op = lfse_pkg::OP_FIT10; state_next = lfse_pkg::ST_FIT11; end
      lfse_pkg::ST_FIT11: begin cmd.op = lfse_pkg::OP_FIT11; state_next = lfse_pkg::ST_FIT12; end
      lfse_pkg::ST_FIT12: begin
        cmd.op     = lfse_pkg::OP_FIT12;
        state_next = lfse_pkg::ST_SL_START;
      end
      lfse_pkg::ST_SL_START: begin
        cmd.op     = lfse_pkg::OP_SLOPE_START;
        state_next = lfse_pkg::ST_SL_WAIT;
      end
      lfse_pkg::ST_SL_WAIT: begin
        if (!status.div_busy) state_next = lfse_pkg::ST_OF_START;
      end
      lfse_pkg::ST_OF_START: begin
        cmd.op     = lfse_pkg::OP_OFFSET_START;
        state_next = lfse_pkg::ST_OF_WAIT;
      end
      lfse_pkg::ST_OF_WAIT: begin
        if (!status.div_busy) state_next = lfse_pkg::ST_VA_START;
      end
      lfse_pkg::ST_VA_START: begin
        cmd.op     = lfse_pkg::OP_VAR_START;
        state_next = lfse_pkg::ST_VA_WAIT;
      end
      lfse_pkg::ST_VA_WAIT: begin
        if (!status.div_busy) state_next = lfse_pkg::ST_VA_TAKE;
      end
      lfse_pkg::ST_VA_TAKE: begin
        cmd.op     = lfse_pkg::OP_VAR_TAKE;
        state_next = lfse_pkg::ST_ER_PREP;
      end
      lfse_pkg::ST_ER_PREP: begin
        cmd.op     = lfse_pkg::OP_ERR_PREP;
        state_next = lfse_pkg::ST_ER_START;
      end
      lfse_pkg::ST_ER_START: begin
        cmd.op     = lfse_pkg::OP_ERR_START;
        state_next = lfse_pkg::ST_ER_WAIT;
      end
      lfse_pkg::ST_ER_WAIT: begin
        if (!status.div_busy) state_next = lfse_pkg::ST_ER_TAKE;
      end
      lfse_pkg::ST_ER_TAKE: begin
        cmd.op     = lfse_pkg::OP_ERR_TAKE;
        state_next = lfse_pkg::ST_OUT;
      end
      lfse_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.op     = lfse_pkg::OP_CLEAR;
          state_next = lfse_pkg::ST_IDLE;
        end
      end
      default: state_next = lfse_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/line_fit_steering_error.sv =====
// least-squares line fit over one frame of track-centre columns
// input channel: one request per image row (row_index, centre_column, last_row);
//   a column of zero marks a row with no point, last_row closes the frame
// output channel: one request per frame with steer error, turn direction,
//   slope, centre offset, column variance and valid point count
// config port: cfg_write with cfg_index 0 sets image_middle, 1 sets turn_threshold
// a row that does not close the frame keeps the block idle, ready for the next row
// the closing row gets its result after a pass over the column store (one entry a
//   cycle through its read port), 13 steps of the shared multiplier, three divisions
//   on the one-bit-a-cycle divider (the slope one is not started when all points
//   share a row) and the error, whose division by 100 is a reciprocal multiply
// a frame with no valid point skips the fit and the divisions
// in_stall stays high from the closing row until the result is taken
// a stalled result holds on the outputs; no new row is taken meanwhile
// reset clears the sums, the error history, held slope and variance and sets
//   the config registers to 128 and 15; the column store needs no clearing
module line_fit_steering_error (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [5:0]                        row_index,
  input  logic [7:0]                        centre_column,
  input  logic                              last_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [23:0]                steer_error,
  output logic [1:0]                        turn_direction,
  output logic signed [15:0]                line_slope,
  output logic signed [16:0]                centre_offset,
  output logic [15:0]                       column_variance,
  output logic [6:0]                        valid_points,
  input  logic                              cfg_write,
  input  logic [lfse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lfse_pkg::CFG_DATA_W-1:0]   cfg_data
);

  lfse_pkg::cmd_t    cmd;
  lfse_pkg::status_t status;

  lfse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_row  (last_row),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  lfse_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .row_index       (row_index),
    .centre_column   (centre_column),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .steer_error     (steer_error),
    .turn_direction  (turn_direction),
    .line_slope      (line_slope),
    .centre_offset   (centre_offset),
    .column_variance (column_variance),
    .valid_points    (valid_points)
  );

endmodule

// ===== rtl/lfse_checker.sv =====
`include "line_fit_steering_error_assert.svh"

module lfse_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [5:0]                        row_index,
  input logic [7:0]                        centre_column,
  input logic                              last_row,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [23:0]                steer_error,
  input logic [1:0]                        turn_direction,
  input logic signed [15:0]                line_slope,
  input logic signed [16:0]                centre_offset,
  input logic [15:0]                       column_variance,
  input logic [6:0]                        valid_points,
  input logic                              cfg_write,
  input logic [lfse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input logic [lfse_pkg::CFG_DATA_W-1:0]   cfg_data
);

  `LFSE_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(steer_error) && $stable(turn_direction), "stalled result changed")

  `LFSE_ASSERT_NOW(a_no_row_during_result, out_valid, in_stall, "row taken while result pending")

  `LFSE_ASSERT_NEXT(a_frame_end_stalls, in_valid && !in_stall && last_row, in_stall && !out_valid, "frame end did not start the solve")

  `LFSE_ASSERT_NOW(a_empty_frame_offset, out_valid && valid_points == 7'd0, centre_offset == 17'sd0, "empty frame gave an offset")

endmodule

bind line_fit_steering_error lfse_checker u_checker (.*);

// ===== verif/tb_line_fit_steering_error.sv =====
`timescale 1ns / 100ps

module tb_line_fit_steering_error;

  typedef struct {
    logic [5:0] row;
    logic [7:0] col;
    logic       last;
  } row_req_t;

  typedef struct {
    logic signed [23:0] err;
    logic [1:0]         dir;
    logic signed [15:0] slope;
    logic signed [16:0] offset;
    logic [15:0]        variance;
    logic [6:0]         points;
  } fit_result_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [5:0] row_index;
  logic [7:0] centre_column;
  logic last_row;
  logic out_valid, out_stall;
  logic signed [23:0] steer_error;
  logic [1:0] turn_direction;
  logic signed [15:0] line_slope;
  logic signed [16:0] centre_offset;
  logic [15:0] column_variance;
  logic [6:0] valid_points;
  logic cfg_write;
  logic [lfse_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lfse_pkg::CFG_DATA_W-1:0] cfg_data;

  line_fit_steering_error dut (.*);

  row_req_t    row_queue[$];
  fit_result_t fit_queue[$];
  int errors = 0;
  int rows_taken = 0;
  int frames_checked = 0;
  int send_idle = 0, recv_idle = 0;
  bit holdoff = 0;
  bit in_fire = 0;

  // predictor state
  logic [7:0] col_mem[lfse_pkg::MAX_ROWS];
  bit         slot_used[lfse_pkg::MAX_ROWS];
  longint     pts, sum_r, sum_c, sum_rc, sum_rr;
  longint     last_err, last_slope, last_var;
  longint     mid_reg, thr_reg;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint lim;
    lim = longint'(1) << (bits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void clear_sums();
    foreach (slot_used[i]) slot_used[i] = 0;
    pts = 0; sum_r = 0; sum_c = 0; sum_rc = 0; sum_rr = 0;
  endfunction

  function automatic void fit_row(logic [5:0] r, logic [7:0] c, logic lst);
    fit_result_t res;
    longint up, down, slope, off, m, p, q, numer, vr, e;
    off = 0;
    col_mem[r] = c;
    slot_used[r] = 1;
    if (c != 0 && pts < lfse_pkg::MAX_ROWS) begin
      pts++;
      sum_r += r; sum_c += c; sum_rc += r * c; sum_rr += r * r;
    end
    if (!lst) return;
    if (pts > 0) begin
      up = pts * sum_rc - sum_r * sum_c;
      down = pts * sum_rr - sum_r * sum_r;
      // all points on one row: denominator treated as 0.001
      if (down > 0) slope = round_div(up * 256, down);
      else slope = round_div(up * 1000 * 256, pts);
      last_slope = clip(slope, 16);
      off = clip(round_div((sum_c - pts * mid_reg) * 256, pts), 17);
      m = 0; p = 0; q = 0;
      for (int i = 0; i < lfse_pkg::MAX_ROWS; i++)
        if (slot_used[i] && col_mem[i] != 0) begin
          m++; p += col_mem[i]; q += col_mem[i] * col_mem[i];
        end
      numer = q * pts * pts - 2 * p * sum_c * pts + m * sum_c * sum_c;
      if (numer < 0) numer = 0;
      vr = numer / (pts * pts * pts);
      last_var = vr > 65535 ? 65535 : vr;
    end
    e = clip(round_div(32 * off + 8 * last_slope + 80 * last_err, 100), 24);
    last_err = e;
    res.err = 24'(e);
    res.dir = e < -thr_reg * 256 ? lfse_pkg::DIR_LEFT :
              (e > thr_reg * 256 ? lfse_pkg::DIR_RIGHT : lfse_pkg::DIR_FORWARD);
    res.slope = 16'(last_slope);
    res.offset = 17'(off);
    res.variance = 16'(last_var);
    res.points = 7'(pts);
    fit_queue.push_back(res);
    clear_sums();
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d (frame %0d)", what, got, want, frames_checked);
  endtask

  // driver
  always @(posedge clk) in_fire <= in_valid && !in_stall;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!(in_valid && !in_fire)) begin
      if (row_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        row_index <= row_queue[0].row;
        centre_column <= row_queue[0].col;
        last_row <= row_queue[0].last;
        in_valid <= 1;
        void'(row_queue.pop_front());
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= holdoff || ($urandom_range(99) < recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      rows_taken++;
      fit_row(row_index, centre_column, last_row);
    end
    if (!rst && out_valid && !out_stall) begin
      if (fit_queue.size() == 0) begin
        report("unexpected result", steer_error, 0);
      end else begin
        fit_result_t w;
        w = fit_queue.pop_front();
        if (steer_error !== w.err) report("steer_error", steer_error, w.err);
        if (turn_direction !== w.dir) report("turn_direction", turn_direction, w.dir);
        if (line_slope !== w.slope) report("line_slope", line_slope, w.slope);
        if (centre_offset !== w.offset) report("centre_offset", centre_offset, w.offset);
        if (column_variance !== w.variance)
          report("column_variance", column_variance, w.variance);
        if (valid_points !== w.points) report("valid_points", valid_points, w.points);
      end
      frames_checked++;
    end
  end

  task automatic push_row(int r, int c, bit lst);
    row_req_t it;
    it.row = 6'(r); it.col = 8'(c); it.last = lst;
    row_queue.push_back(it);
  endtask

  task automatic settle();
    while (row_queue.size() > 0 || in_valid || fit_queue.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(logic [lfse_pkg::CFG_INDEX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= lfse_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_write <= 0;
    if (idx == lfse_pkg::REG_IMAGE_MIDDLE) mid_reg = val;
    else thr_reg = val;
  endtask

  task automatic random_frame();
    int kind, len, start, base, step, c;
    kind = $urandom_range(19);
    if (kind == 0) begin
      // noise: arbitrary rows and columns
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        push_row($urandom_range(63), $urandom_range(255), i == len - 1);
    end else if (kind == 1) begin
      // more valid rows than the store holds
      len = $urandom_range(66, 80);
      for (int i = 0; i < len; i++)
        push_row($urandom_range(63), $urandom_range(1, 255), i == len - 1);
    end else if (kind == 2) begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) push_row($urandom_range(63), 0, i == len - 1);
    end else begin
      len = $urandom_range(3, 30);
      start = $urandom_range(63);
      base = $urandom_range(255);
      step = $urandom_range(0, 12) - 6;
      for (int i = 0; i < len; i++) begin
        c = base + step * i + $urandom_range(0, 8) - 4;
        if (c < 0) c = 0;
        if (c > 255) c = 255;
        if ($urandom_range(9) == 0) c = 0;
        push_row((start + i) % 64, c, i == len - 1);
      end
    end
  endtask

  task automatic random_phase(int rows);
    int target;
    target = rows_taken + row_queue.size() + rows;
    while (rows_taken + row_queue.size() < target) random_frame();
  endtask

  initial begin
    rst = 1;
    in_valid = 0; row_index = 0; centre_column = 0; last_row = 0;
    out_stall = 0; cfg_write = 0; cfg_index = 0; cfg_data = 0;
    mid_reg = lfse_pkg::IMAGE_MIDDLE_RESET; thr_reg = lfse_pkg::TURN_THRESHOLD_RESET;
    last_err = 0; last_slope = 0; last_var = 0;
    foreach (col_mem[i]) col_mem[i] = 0;
    clear_sums();
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed frames at reset settings
    push_row(0, 255, 0); push_row(63, 1, 1);       // extreme rows and columns
    push_row(5, 1, 0); push_row(6, 255, 1);        // steep slope saturates
    push_row(10, 0, 1);                            // frame with no point
    push_row(3, 200, 1);                           // single point
    push_row(7, 50, 0); push_row(7, 90, 1);        // repeated row, flat denominator
    for (int i = 0; i < 10; i++) push_row(20 + i, 100 + 3 * i, i == 9);
    settle();

    send_idle = 21; recv_idle = 70;
    set_reg(lfse_pkg::REG_IMAGE_MIDDLE, 0);
    set_reg(lfse_pkg::REG_TURN_THRESHOLD, 0);
    random_phase(530);
    settle();

    send_idle = 70; recv_idle = 21;
    set_reg(lfse_pkg::REG_IMAGE_MIDDLE, 255);
    set_reg(lfse_pkg::REG_TURN_THRESHOLD, 255);
    random_phase(530);
    settle();

    send_idle = 0; recv_idle = 0;
    set_reg(lfse_pkg::REG_IMAGE_MIDDLE, $urandom_range(255));
    set_reg(lfse_pkg::REG_TURN_THRESHOLD, $urandom_range(1, 40));
    // long receiver hold-off while rows keep coming
    holdoff = 1;
    random_phase(530);
    repeat (700) @(posedge clk);
    holdoff = 0;
    settle();

    repeat (300) @(posedge clk);
    $display("covered %0d row requests and %0d frame results", rows_taken, frames_checked);
    $display("over four settings of image middle and turn threshold, %0d mismatches", errors);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
